FILE: hw/rtl/s7mv_pkg.sv
`default_nettype none

package s7mv_pkg;

    // grid bounds of the stores
    localparam int MAX_X_DEF = 32;
    localparam int MAX_Y_DEF = 32;
    localparam int MAX_Z_DEF = 32;

    // field widths
    localparam int DATA_W  = 32;
    localparam int COORD_W = 5;
    localparam int SIZE_W  = 6;
    localparam int PROD_W  = 2 * DATA_W;
    // seven q32.32 products plus the shifted rhs fit with margin
    localparam int ACC_W   = 68;
    localparam int FRAC_W  = 16;

    // configuration register indexes
    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t REG_SIZE_X        = 2'd0;
    localparam cfg_idx_t REG_SIZE_Y        = 2'd1;
    localparam cfg_idx_t REG_SIZE_Z        = 2'd2;
    localparam cfg_idx_t REG_RESIDUAL_MODE = 2'd3;

    // request codes
    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    // stencil terms in issue order
    typedef logic [2:0] term_t;
    localparam term_t TERM_CENTER = 3'd0;
    localparam term_t TERM_XM     = 3'd1;
    localparam term_t TERM_XP     = 3'd2;
    localparam term_t TERM_YM     = 3'd3;
    localparam term_t TERM_YP     = 3'd4;
    localparam term_t TERM_ZM     = 3'd5;
    localparam term_t TERM_ZP     = 3'd6;
    localparam int    NUM_TERMS   = 7;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RUN   = 5'b00010,
        ST_FOLD  = 5'b00100,
        ST_ROUND = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

endpackage

`default_nettype wire

FILE: hw/rtl/stencil_7pt_matvec_residual_top.sv
`default_nettype none

// Seven-point stencil matrix-vector / residual engine. Six stores of
// MAX_X*MAX_Y*MAX_Z signed Q16.16 words hold the center, right, up and front
// coefficients, the vector and the right-hand side of every cell. A load
// transfer (req_type 0) writes all six words of one cell at once, and loads
// may follow each other every cycle while the block is idle; cells at or
// beyond the MAX_ bounds are dropped. A compute transfer (req_type 1) returns
// A*x, or b - A*x when residual_mode is set, at one cell; neighbors outside
// size_x/y/z count as zero. The seven products are summed exactly, rounded to
// nearest (ties up) into Q16.16 and clamped to 32 bits with the saturated
// flag. A compute request for a cell outside the configured size returns 0
// with out_of_range set, stalling the input until that result is loaded into
// the output register. An in-range compute keeps the input stalled while the
// single 32x32 multiplier takes one stencil term per cycle, then while the
// memory read and product registers drain, the residual fold and the rounding
// add run and the output register is loaded once it is free. Store contents
// are undefined until loaded; reading a cell that was never loaded gives
// undefined data. Configuration writes are taken at any time but only make
// sense while the block is idle.
module stencil_7pt_matvec_residual_top
    #(
        parameter int MAX_X = s7mv_pkg::MAX_X_DEF,
        parameter int MAX_Y = s7mv_pkg::MAX_Y_DEF,
        parameter int MAX_Z = s7mv_pkg::MAX_Z_DEF
    )
    (
        input  wire logic                               clk,
        input  wire logic                               rst_n,

        // configuration write port
        input  wire logic                               cfg_wr_en,
        input  wire s7mv_pkg::cfg_idx_t                 cfg_index,
        input  wire logic [s7mv_pkg::SIZE_W-1:0]        cfg_data,

        // request channel
        input  wire logic                               in_valid,
        output logic                                    in_stall,
        input  wire logic                               req_type,
        input  wire logic [s7mv_pkg::COORD_W-1:0]       cell_x,
        input  wire logic [s7mv_pkg::COORD_W-1:0]       cell_y,
        input  wire logic [s7mv_pkg::COORD_W-1:0]       cell_z,
        input  wire logic signed [s7mv_pkg::DATA_W-1:0] coef_center,
        input  wire logic signed [s7mv_pkg::DATA_W-1:0] coef_right,
        input  wire logic signed [s7mv_pkg::DATA_W-1:0] coef_up,
        input  wire logic signed [s7mv_pkg::DATA_W-1:0] coef_front,
        input  wire logic signed [s7mv_pkg::DATA_W-1:0] vec_value,
        input  wire logic signed [s7mv_pkg::DATA_W-1:0] rhs_value,

        // result channel
        output logic                                    out_valid,
        input  wire logic                               out_stall,
        output logic signed [s7mv_pkg::DATA_W-1:0]      result_value,
        output logic                                    saturated,
        output logic                                    out_of_range
    );

    import s7mv_pkg::*;

    localparam int CELLS  = MAX_X * MAX_Y * MAX_Z;
    localparam int AW     = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PLANE  = MAX_X * MAX_Y;
    localparam int RUN_W  = 4;
    // last counter value of the run phase: all terms issued and accumulated
    localparam int RUN_LAST = NUM_TERMS + 1;

    localparam logic [AW-1:0] STEP_X = AW'(1);
    localparam logic [AW-1:0] STEP_Y = AW'(MAX_X);
    localparam logic [AW-1:0] STEP_Z = AW'(PLANE);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] size_x_reg;
    logic [SIZE_W-1:0] size_y_reg;
    logic [SIZE_W-1:0] size_z_reg;
    logic              residual_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg        <= SIZE_W'(32);
            size_y_reg        <= SIZE_W'(32);
            size_z_reg        <= SIZE_W'(32);
            residual_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SIZE_X:        size_x_reg        <= cfg_data;
                REG_SIZE_Y:        size_y_reg        <= cfg_data;
                REG_SIZE_Z:        size_z_reg        <= cfg_data;
                REG_RESIDUAL_MODE: residual_mode_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------
    state_t state_reg;
    state_t state_next;

    logic        in_xfer;
    logic        load_xfer;
    logic        comp_xfer;
    logic        in_store;
    logic        in_grid;
    logic [31:0] in_x32;
    logic [31:0] in_y32;
    logic [31:0] in_z32;
    logic [31:0] in_idx_full;
    logic [AW-1:0] in_idx;
    logic [NUM_TERMS-1:0] in_en;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign load_xfer = in_xfer && (req_type == REQ_LOAD);
    assign comp_xfer = in_xfer && (req_type == REQ_COMPUTE);

    assign in_x32 = 32'(cell_x);
    assign in_y32 = 32'(cell_y);
    assign in_z32 = 32'(cell_z);

    // linear cell index, multiplications by elaboration constants
    assign in_idx_full = in_z32 * 32'(PLANE) + in_y32 * 32'(MAX_X) + in_x32;
    assign in_idx      = in_idx_full[AW-1:0];

    // cell exists in the stores
    assign in_store = (in_x32 < 32'(MAX_X)) && (in_y32 < 32'(MAX_Y))
                   && (in_z32 < 32'(MAX_Z));

    // cell lies in the configured grid (size clipped to the store bounds)
    assign in_grid = in_store
                  && (in_x32 < 32'(size_x_reg)) && (in_y32 < 32'(size_y_reg))
                  && (in_z32 < 32'(size_z_reg));

    // which stencil neighbors contribute
    always_comb
    begin
        in_en              = '0;
        in_en[TERM_CENTER] = 1'b1;
        in_en[TERM_XM]     = (cell_x != '0);
        in_en[TERM_XP]     = (in_x32 + 32'd1 < 32'(size_x_reg))
                          && (in_x32 + 32'd1 < 32'(MAX_X));
        in_en[TERM_YM]     = (cell_y != '0);
        in_en[TERM_YP]     = (in_y32 + 32'd1 < 32'(size_y_reg))
                          && (in_y32 + 32'd1 < 32'(MAX_Y));
        in_en[TERM_ZM]     = (cell_z != '0);
        in_en[TERM_ZP]     = (in_z32 + 32'd1 < 32'(size_z_reg))
                          && (in_z32 + 32'd1 < 32'(MAX_Z));
    end

    // ------------------------------------------------------------------
    // sequencer registers
    // ------------------------------------------------------------------
    logic [AW-1:0]        base_reg;
    logic [NUM_TERMS-1:0] en_reg;
    logic                 oor_reg;
    logic [RUN_W-1:0]     cnt_reg;
    logic [RUN_W-1:0]     cnt_next;
    term_t                issue_term;
    logic                 issue;

    assign issue_term = cnt_reg[2:0];
    assign issue      = (state_reg == ST_RUN) && (cnt_reg < RUN_W'(NUM_TERMS));

    always_ff @(posedge clk)
    begin
        if (comp_xfer)
        begin
            base_reg <= in_idx;
            en_reg   <= in_en;
            oor_reg  <= !in_grid;
        end
    end

    // ------------------------------------------------------------------
    // fetch addresses: coefficient of the owning row and the vector element
    // of the neighbor; a lower neighbor stores the shared coefficient itself
    // ------------------------------------------------------------------
    logic [AW-1:0] coef_addr;
    logic [AW-1:0] vec_addr;

    always_comb
    begin
        case (issue_term)
            TERM_CENTER:
            begin
                coef_addr = base_reg;
                vec_addr  = base_reg;
            end
            TERM_XM:
            begin
                coef_addr = base_reg - STEP_X;
                vec_addr  = base_reg - STEP_X;
            end
            TERM_XP:
            begin
                coef_addr = base_reg;
                vec_addr  = base_reg + STEP_X;
            end
            TERM_YM:
            begin
                coef_addr = base_reg - STEP_Y;
                vec_addr  = base_reg - STEP_Y;
            end
            TERM_YP:
            begin
                coef_addr = base_reg;
                vec_addr  = base_reg + STEP_Y;
            end
            TERM_ZM:
            begin
                coef_addr = base_reg - STEP_Z;
                vec_addr  = base_reg - STEP_Z;
            end
            TERM_ZP:
            begin
                coef_addr = base_reg;
                vec_addr  = base_reg + STEP_Z;
            end
            default:
            begin
                coef_addr = base_reg;
                vec_addr  = base_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // stores: one write port shared by loads, one registered read each
    // ------------------------------------------------------------------
    logic mem_we;
    assign mem_we = load_xfer && in_store;

    logic [DATA_W-1:0] center_mem [CELLS];
    logic [DATA_W-1:0] right_mem  [CELLS];
    logic [DATA_W-1:0] up_mem     [CELLS];
    logic [DATA_W-1:0] front_mem  [CELLS];
    logic [DATA_W-1:0] vec_mem    [CELLS];
    logic [DATA_W-1:0] rhs_mem    [CELLS];

    logic [DATA_W-1:0] center_rd_reg;
    logic [DATA_W-1:0] right_rd_reg;
    logic [DATA_W-1:0] up_rd_reg;
    logic [DATA_W-1:0] front_rd_reg;
    logic [DATA_W-1:0] vec_rd_reg;
    logic [DATA_W-1:0] rhs_rd_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            center_mem[in_idx] <= coef_center;
        end
        center_rd_reg <= center_mem[coef_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            right_mem[in_idx] <= coef_right;
        end
        right_rd_reg <= right_mem[coef_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            up_mem[in_idx] <= coef_up;
        end
        up_rd_reg <= up_mem[coef_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            front_mem[in_idx] <= coef_front;
        end
        front_rd_reg <= front_mem[coef_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vec_mem[in_idx] <= vec_value;
        end
        vec_rd_reg <= vec_mem[vec_addr];
    end

    // rhs is only ever needed at the center cell
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rhs_mem[in_idx] <= rhs_value;
        end
        rhs_rd_reg <= rhs_mem[base_reg];
    end

    // ------------------------------------------------------------------
    // multiply and accumulate pipeline: read -> product -> accumulator
    // ------------------------------------------------------------------
    term_t                    rd_term_reg;
    logic                     rd_vld_reg;
    logic                     prod_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DATA_W-1:0] coef_sel;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  rhs_shift;

    always_comb
    begin
        case (rd_term_reg)
            TERM_CENTER:                coef_sel = center_rd_reg;
            TERM_XM, TERM_XP:           coef_sel = right_rd_reg;
            TERM_YM, TERM_YP:           coef_sel = up_rd_reg;
            TERM_ZM, TERM_ZP:           coef_sel = front_rd_reg;
            default:                    coef_sel = center_rd_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg && en_reg[rd_term_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        rd_term_reg <= issue_term;
        prod_reg    <= coef_sel * signed'(vec_rd_reg);
    end

    // b in q32.32
    assign rhs_shift = {{(ACC_W - DATA_W - FRAC_W){rhs_rd_reg[DATA_W-1]}},
                        rhs_rd_reg, {FRAC_W{1'b0}}};

    // the one wide adder: accumulate, residual fold, rounding offset
    always_comb
    begin
        acc_next = acc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                acc_next = '0;
            end
            ST_RUN:
            begin
                if (prod_vld_reg)
                begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                end
            end
            ST_FOLD:
            begin
                if (residual_mode_reg)
                begin
                    acc_next = rhs_shift - acc_reg;
                end
            end
            ST_ROUND:
            begin
                // round half up before the floor shift
                acc_next = acc_reg + ACC_W'(1 << (FRAC_W - 1));
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // ------------------------------------------------------------------
    // saturation of the rounded value
    // ------------------------------------------------------------------
    localparam int TOP_LO = DATA_W + FRAC_W - 1;

    logic                     fits;
    logic signed [DATA_W-1:0] clamp_val;

    // floor(acc / 2^16) fits in 32 bits when all bits above it match the sign
    assign fits = (acc_reg[ACC_W-1:TOP_LO] == '0) || (acc_reg[ACC_W-1:TOP_LO] == '1);

    always_comb
    begin
        if (fits)
        begin
            clamp_val = acc_reg[TOP_LO:FRAC_W];
        end
        else if (acc_reg[ACC_W-1])
        begin
            clamp_val = SAT_MIN;
        end
        else
        begin
            clamp_val = SAT_MAX;
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    logic out_free;
    logic out_vld_reg;
    logic emit;

    assign out_free = !out_vld_reg || !out_stall;
    assign emit     = (state_reg == ST_EMIT) && out_free;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (comp_xfer)
                begin
                    state_next = in_grid ? ST_RUN : ST_EMIT;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + RUN_W'(1);
                if (cnt_reg == RUN_W'(RUN_LAST))
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] result_reg;
    logic                     sat_reg;
    logic                     oor_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg  <= oor_reg ? '0 : clamp_val;
            sat_reg     <= !oor_reg && !fits;
            oor_out_reg <= oor_reg;
        end
    end

    assign out_valid    = out_vld_reg;
    assign result_value = result_reg;
    assign saturated    = sat_reg;
    assign out_of_range = oor_out_reg;

endmodule

`default_nettype wire
